// ===== design/itoa_pkg.sv =====
// Package with shared constants, types and the power-of-ten weight table for the converter.
package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CMP_W      = VALUE_BITS + 4;
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

  // Number of decimal digits in the largest magnitude, 2^(VALUE_BITS-1).
  function automatic int count_digits();
    logic [63:0] m;
    int          n;
    m = 64'd1 << (VALUE_BITS - 1);
    n = 0;
    while (m != 64'd0) begin
      m = m / 64'd10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int NUM_DIGITS = count_digits();
  localparam int K_W        = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  typedef logic [NUM_DIGITS-1:0][CMP_W-1:0] pow_tbl_t;

  function automatic pow_tbl_t init_pow10();
    pow_tbl_t    t;
    logic [63:0] p;
    t = '0;
    p = 64'd1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      t[i] = CMP_W'(p);
      p = p * 64'd10;
    end
    return t;
  endfunction

  localparam pow_tbl_t POW10_TBL = init_pow10();

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } itoa_state_t;

  // Control from the sequencer to the compare/subtract unit.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       first;
    logic [1:0] shamt;
  } csub_ctrl_t;

endpackage

// ===== design/itoa_csub.sv =====
// Shared compare/subtract unit that holds the remainder and builds one decimal digit.
module itoa_csub
  import itoa_pkg::*;
(
  input  logic                  clk,
  input  csub_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0] load_mag,
  input  logic [CMP_W-1:0]      weight,
  output logic [3:0]            digit
);

  logic [VALUE_BITS-1:0] rem_r;
  logic [VALUE_BITS-1:0] rem_nxt;
  logic [3:0]            digit_r;
  logic [3:0]            digit_nxt;
  logic                  ge;

  always_comb begin
    ge        = {{(CMP_W-VALUE_BITS){1'b0}}, rem_r} >= weight;
    rem_nxt   = ge ? (rem_r - weight[VALUE_BITS-1:0]) : rem_r;
    digit_nxt = (ctrl.first ? 4'd0 : digit_r) | ({3'd0, ge} << ctrl.shamt);
  end

  assign digit = digit_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r   <= load_mag;
      digit_r <= 4'd0;
    end else if (ctrl.step) begin
      rem_r   <= rem_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

// ===== design/int32_to_decimal_ascii_top.sv =====
// Top level: signed integer to decimal ASCII converter with its sequencer.
// A minus sign, when needed, is registered and appears in the cycle after start; each
// digit is built in four compare/subtract steps, and the last character is registered
// after the final step of the units digit. A new value is taken only in idle, so the
// single compare/subtract unit converts one value at a time.
// Results cannot be stalled. Reset (rst_n low, synchronous) returns to idle.
module int32_to_decimal_ascii_top
  import itoa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_character,
  output logic                  out_last
);

  itoa_state_t       state_r, state_nxt;
  logic [K_W-1:0]    k_r, k_nxt;         // current decade, counts down to zero
  logic [1:0]        b_r, b_nxt;         // step within the decade: weights 8,4,2,1
  logic              started_r, started_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  csub_ctrl_t            ctrl;
  logic [VALUE_BITS-1:0] mag;
  logic [CMP_W-1:0]      weight;
  logic [3:0]            digit;
  logic                  negative;

  // Magnitude at full width: the most negative value maps to 2^(VALUE_BITS-1).
  assign negative = in_value[VALUE_BITS-1];
  assign mag      = negative ? (~in_value + VALUE_BITS'(1)) : in_value;

  // Trial weight is the decade's power of ten scaled by 8, 4, 2 or 1.
  assign weight = POW10_TBL[k_r] << (2'd3 - b_r);

  itoa_csub u_csub (
    .clk      (clk),
    .ctrl     (ctrl),
    .load_mag (mag),
    .weight   (weight),
    .digit    (digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      b_r         <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      b_r         <= b_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    b_nxt         = b_r;
    started_nxt   = started_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl.load     = 1'b0;
    ctrl.step     = 1'b0;
    ctrl.first    = (b_r == 2'd0);
    ctrl.shamt    = 2'd3 - b_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Load the magnitude and emit the minus sign right away when needed.
          ctrl.load     = 1'b1;
          state_nxt     = ST_CONV;
          k_nxt         = K_W'(NUM_DIGITS - 1);
          b_nxt         = 2'd0;
          started_nxt   = 1'b0;
          out_valid_nxt = negative;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      ST_CONV: begin
        ctrl.step = 1'b1;
        b_nxt     = b_r + 2'd1;
        if (b_r == 2'd3) begin
          // Digit complete; leading zeros are dropped, but the units digit always shows.
          if (started_r || (digit != 4'd0) || (k_r == '0)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, digit};
            out_last_nxt  = (k_r == '0);
            started_nxt   = 1'b1;
          end
          if (k_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r - K_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule
